// File: design/csvx_pkg.sv
// Package for the CSV column extractor: parse modes, character codes and
// byte class helpers. No dependencies.
package csvx_pkg;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    localparam logic [7:0] TARGET_RESET = 8'd12;
    localparam logic [7:0] COLUMN_MAX   = 8'd255;

    typedef enum logic [2:0] {
        M_START,
        M_SKIP_U,
        M_SKIP_Q,
        M_SKIP_QS,
        M_TGT_U,
        M_TGT_Q,
        M_TGT_QS,
        M_DONE
    } t_mode;

    function automatic logic is_ws(input logic [7:0] b);
        is_ws = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

    function automatic logic is_term(input logic [7:0] b);
        is_term = (b == CH_NUL) || (b == CH_LF) || (b == CH_CR);
    endfunction

endpackage

// File: design/csvx_ram.sv
// Generic simple dual-port RAM, one write and one read port, registered read.
// No dependencies.
module csvx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 63,
    parameter int AW    = 6
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/csv_column_extractor.sv
// CSV column extractor: top level with parser state, held-whitespace RAM and
// result sequencer. Depends on csvx_pkg and csvx_ram.
// Flow: a byte that yields no result is taken while the sequencer idles; for any
// other byte input stalls while the sequencer replays each held whitespace byte
// from the RAM (one read, one output), then sends the field byte, the closing result, or both.
// Reset: synchronous active-low; parser rearms, target column returns to 12.
// The whitespace RAM needs no clearing pass.
module csv_column_extractor #(
    parameter int FIELD_CAPACITY = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] line_byte
    input  logic       i_s_tlast,   // line_end
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] field_byte
    output logic [1:0] o_m_tuser,   // [0] is_closing, [1] column_found
    output logic       o_m_tlast    // burst_last
);

    localparam int DEPTH = FIELD_CAPACITY - 1;
    localparam int CW    = $clog2(FIELD_CAPACITY);
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CW-1:0] KEEP_MAX = CW'(FIELD_CAPACITY - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_EMIT,
        S_BYTE,
        S_CLOSE
    } t_state;

    // parser state
    logic [7:0]         r_tgt;
    logic [7:0]         r_col,  n_col;
    csvx_pkg::t_mode    r_mode, n_mode;
    logic [CW-1:0]      r_kept, n_kept;
    logic               r_lead, n_lead;
    logic [CW-1:0]      r_pend, n_pend;

    // sequencer
    t_state             r_state;
    logic [7:0]         r_byte;
    logic               r_close;
    logic               r_found;
    logic [CW-1:0]      r_fcnt;
    logic [CW-1:0]      r_idx;

    logic [7:0]         r_o_data;
    logic               r_o_valid;
    logic               r_o_close;
    logic               r_o_found;
    logic               r_o_last;

    // step results
    logic               s_emit;
    logic               s_wr;
    logic [CW-1:0]      s_flush;
    logic               s_close;
    logic               s_found;

    logic               accept;
    logic               out_free;
    logic               out_load;
    logic [7:0]         ram_rdata;
    logic [7:0]         b;
    logic               take;

    assign accept     = i_s_tvalid && (r_state == S_IDLE);
    assign out_free   = !r_o_valid || i_m_tready;
    assign out_load   = out_free && ((r_state == S_EMIT) || (r_state == S_BYTE) ||
                                     (r_state == S_CLOSE));
    assign o_s_tready = (r_state == S_IDLE);
    assign b          = i_s_tdata;

    always_comb begin
        n_mode  = r_mode;
        n_col   = r_col;
        n_kept  = r_kept;
        n_lead  = r_lead;
        n_pend  = r_pend;
        take    = 1'b0;
        s_close = 1'b0;
        s_found = 1'b0;
        s_emit  = 1'b0;
        s_wr    = 1'b0;
        s_flush = r_pend;

        unique case (r_mode)
            csvx_pkg::M_START: begin
                if (csvx_pkg::is_term(b)) begin
                    s_close = 1'b1;
                end else if (r_col == r_tgt) begin
                    if (b == csvx_pkg::CH_QUOTE) begin
                        n_mode = csvx_pkg::M_TGT_Q;
                    end else if (b == csvx_pkg::CH_COMMA) begin
                        s_close = 1'b1;
                        s_found = 1'b1;
                    end else begin
                        n_mode = csvx_pkg::M_TGT_U;
                        take   = 1'b1;
                    end
                end else if (b == csvx_pkg::CH_QUOTE) begin
                    n_mode = csvx_pkg::M_SKIP_Q;
                end else if (b == csvx_pkg::CH_COMMA) begin
                    if (r_col != csvx_pkg::COLUMN_MAX) n_col = r_col + 8'd1;
                end else begin
                    n_mode = csvx_pkg::M_SKIP_U;
                end
            end
            csvx_pkg::M_SKIP_U: begin
                if (csvx_pkg::is_term(b)) begin
                    s_close = 1'b1;
                end else if (b == csvx_pkg::CH_COMMA) begin
                    if (r_col != csvx_pkg::COLUMN_MAX) n_col = r_col + 8'd1;
                    n_mode = csvx_pkg::M_START;
                end
            end
            csvx_pkg::M_SKIP_Q: begin
                if (b == csvx_pkg::CH_NUL) begin
                    s_close = 1'b1;
                end else if (b == csvx_pkg::CH_QUOTE) begin
                    n_mode = csvx_pkg::M_SKIP_QS;
                end
            end
            csvx_pkg::M_SKIP_QS: begin
                if (b == csvx_pkg::CH_QUOTE) begin
                    n_mode = csvx_pkg::M_SKIP_Q;
                end else if (b == csvx_pkg::CH_COMMA) begin
                    if (r_col != csvx_pkg::COLUMN_MAX) n_col = r_col + 8'd1;
                    n_mode = csvx_pkg::M_START;
                end else if (csvx_pkg::is_term(b)) begin
                    s_close = 1'b1;
                end else begin
                    n_mode = csvx_pkg::M_SKIP_U;
                end
            end
            csvx_pkg::M_TGT_U: begin
                if (csvx_pkg::is_term(b) || b == csvx_pkg::CH_COMMA) begin
                    s_close = 1'b1;
                    s_found = 1'b1;
                end else begin
                    take = 1'b1;
                end
            end
            csvx_pkg::M_TGT_Q: begin
                if (b == csvx_pkg::CH_NUL) begin
                    s_close = 1'b1;
                    s_found = 1'b1;
                end else if (b == csvx_pkg::CH_QUOTE) begin
                    n_mode = csvx_pkg::M_TGT_QS;
                end else begin
                    take = 1'b1;
                end
            end
            csvx_pkg::M_TGT_QS: begin
                if (b == csvx_pkg::CH_QUOTE) begin
                    n_mode = csvx_pkg::M_TGT_Q;
                    take   = 1'b1;
                end else begin
                    s_close = 1'b1;
                    s_found = 1'b1;
                end
            end
            csvx_pkg::M_DONE: begin
            end
            default: begin
            end
        endcase

        // content bytes past capacity are dropped untouched
        if (take && (r_kept < KEEP_MAX)) begin
            n_kept = r_kept + CW'(1);
            if (csvx_pkg::is_ws(b)) begin
                if (!r_lead && (r_pend < KEEP_MAX)) begin
                    s_wr   = 1'b1;
                    n_pend = r_pend + CW'(1);
                end
            end else begin
                s_emit = 1'b1;
                n_pend = '0;
                n_lead = 1'b0;
            end
        end

        if (s_close) n_mode = csvx_pkg::M_DONE;

        if (i_s_tlast) begin
            if (n_mode != csvx_pkg::M_DONE) begin
                s_close = 1'b1;
                s_found = (n_mode == csvx_pkg::M_TGT_U) || (n_mode == csvx_pkg::M_TGT_Q) ||
                          (n_mode == csvx_pkg::M_TGT_QS);
            end
            n_col  = 8'd1;
            n_mode = csvx_pkg::M_START;
            n_kept = '0;
            n_lead = 1'b1;
            n_pend = '0;
        end
    end

    csvx_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_pend_ram (
        .i_clk   (i_clk),
        .i_we    (accept && s_wr),
        .i_waddr (r_pend[AW-1:0]),
        .i_wdata (b),
        .i_re    (r_state == S_RD),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tgt <= csvx_pkg::TARGET_RESET;
        end else if (i_cfg_we) begin
            r_tgt <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= 8'd1;
            r_mode    <= csvx_pkg::M_START;
            r_kept    <= '0;
            r_lead    <= 1'b1;
            r_pend    <= '0;
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= out_load || (r_o_valid && !i_m_tready);

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_col   <= n_col;
                        r_mode  <= n_mode;
                        r_kept  <= n_kept;
                        r_lead  <= n_lead;
                        r_pend  <= n_pend;
                        r_byte  <= b;
                        r_close <= s_close;
                        r_found <= s_found;
                        r_fcnt  <= s_flush;
                        r_idx   <= '0;
                        if (s_emit) begin
                            r_state <= (s_flush != '0) ? S_RD : S_BYTE;
                        end else if (s_close) begin
                            r_state <= S_CLOSE;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_o_data  <= ram_rdata;
                        r_o_close <= 1'b0;
                        r_o_found <= 1'b0;
                        r_o_last  <= 1'b0;
                        if (r_idx == r_fcnt - CW'(1)) begin
                            r_state <= S_BYTE;
                        end else begin
                            r_idx   <= r_idx + CW'(1);
                            r_state <= S_RD;
                        end
                    end
                end
                S_BYTE: begin
                    if (out_free) begin
                        r_o_data  <= r_byte;
                        r_o_close <= 1'b0;
                        r_o_found <= 1'b0;
                        r_o_last  <= !r_close;
                        r_state   <= r_close ? S_CLOSE : S_IDLE;
                    end
                end
                S_CLOSE: begin
                    if (out_free) begin
                        r_o_data  <= 8'd0;
                        r_o_close <= 1'b1;
                        r_o_found <= r_found;
                        r_o_last  <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_data;
    assign o_m_tuser  = {r_o_found, r_o_close};
    assign o_m_tlast  = r_o_last;

endmodule

// File: dv/tb_csv_column_extractor.sv
// Testbench for csv_column_extractor: directed lines from a table, then random
// CSV lines under several target columns, checked against an in-bench parser.
// Depends on csvx_pkg and the design sources.
module tb_csv_column_extractor;

    localparam int FIELD_CAP    = 64;
    localparam int DRAIN_CYCLES = 20;
    localparam int WATCH_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 8;
    localparam int N_PHASES     = 6;

    typedef enum logic {ROW_BYTE, ROW_CFG} t_row_kind;

    // val is the byte, or the target column for ROW_CFG; typed rows carry
    // their expectation: n_one = one closing result with found = fnd
    typedef struct packed {
        t_row_kind  kind;
        logic [7:0] val;
        logic       fin;
        logic       typed;
        logic       n_one;
        logic       fnd;
    } t_row;

    typedef struct packed {
        logic [7:0] fbyte;
        logic       closing;
        logic       found;
        logic       last;
    } t_field_out;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic [7:0] i_cfg_wdata = 8'h00;
    logic       i_s_tvalid  = 1'b0;
    logic [7:0] i_s_tdata   = 8'h00;
    logic       i_s_tlast   = 1'b0;
    logic       i_m_tready  = 1'b0;
    logic       o_s_tready;
    logic       o_m_tvalid;
    logic [7:0] o_m_tdata;
    logic [1:0] o_m_tuser;
    logic       o_m_tlast;

    csv_column_extractor #(.FIELD_CAPACITY(FIELD_CAP)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

    always #5 i_clk = ~i_clk;

    // parser copy
    logic [7:0]      tgt_col;
    logic [7:0]      col_num;
    csvx_pkg::t_mode pmode;
    int              kept_n;
    logic            lead_ws;
    logic [7:0]      ws_hold [0:FIELD_CAP-2];
    int              ws_n;

    t_field_out field_out_q [$];
    t_field_out step_q [$];
    logic [7:0] line_bytes [$];

    // tag that travels with the byte on the input side
    logic row_typed = 1'b0;
    logic row_n     = 1'b0;
    logic row_found = 1'b0;

    bit quiet     = 1'b0;
    int hold_left = 0;
    int mismatches = 0;
    int stall_cnt  = 0;

    t_row dir_rows [0:27] = '{
        '{ROW_BYTE, csvx_pkg::CH_LF,    1'b1, 1'b1, 1'b1, 1'b0},   // reset target 12
        '{ROW_CFG,  8'd1,               1'b0, 1'b0, 1'b0, 1'b0},
        '{ROW_BYTE, csvx_pkg::CH_COMMA, 1'b0, 1'b1, 1'b1, 1'b1},   // empty before comma
        '{ROW_BYTE, csvx_pkg::CH_NUL,   1'b1, 1'b1, 1'b0, 1'b0},   // ignored after close
        '{ROW_BYTE, csvx_pkg::CH_CR,    1'b1, 1'b1, 1'b1, 1'b0},   // empty at line end
        '{ROW_BYTE, csvx_pkg::CH_QUOTE, 1'b0, 1'b0, 1'b0, 1'b0},   // quoted target
        '{ROW_BYTE, csvx_pkg::CH_SPACE, 1'b0, 1'b0, 1'b0, 1'b0},
        '{ROW_BYTE, 8'h61,              1'b0, 1'b0, 1'b0, 1'b0},
        '{ROW_BYTE, csvx_pkg::CH_COMMA, 1'b0, 1'b0, 1'b0, 1'b0},
        '{ROW_BYTE, csvx_pkg::CH_LF,    1'b0, 1'b0, 1'b0, 1'b0},
        '{ROW_BYTE, csvx_pkg::CH_QUOTE, 1'b0, 1'b0, 1'b0, 1'b0},
        '{ROW_BYTE, csvx_pkg::CH_QUOTE, 1'b0, 1'b0, 1'b0, 1'b0},
        '{ROW_BYTE, csvx_pkg::CH_SPACE, 1'b0, 1'b0, 1'b0, 1'b0},
        '{ROW_BYTE, csvx_pkg::CH_TAB,   1'b0, 1'b0, 1'b0, 1'b0},
        '{ROW_BYTE, 8'h62,              1'b0, 1'b0, 1'b0, 1'b0},
        '{ROW_BYTE, csvx_pkg::CH_SPACE, 1'b0, 1'b0, 1'b0, 1'b0},
        '{ROW_BYTE, csvx_pkg::CH_QUOTE, 1'b1, 1'b0, 1'b0, 1'b0},   // closing quote last
        '{ROW_CFG,  8'd2,               1'b0, 1'b0, 1'b0, 1'b0},
        '{ROW_BYTE, csvx_pkg::CH_QUOTE, 1'b0, 1'b0, 1'b0, 1'b0},   // skipped quoted, CR
        '{ROW_BYTE, csvx_pkg::CH_CR,    1'b0, 1'b0, 1'b0, 1'b0},
        '{ROW_BYTE, csvx_pkg::CH_QUOTE, 1'b0, 1'b0, 1'b0, 1'b0},
        '{ROW_BYTE, 8'h78,              1'b0, 1'b0, 1'b0, 1'b0},   // junk after quote
        '{ROW_BYTE, csvx_pkg::CH_COMMA, 1'b0, 1'b0, 1'b0, 1'b0},
        '{ROW_BYTE, 8'h79,              1'b0, 1'b0, 1'b0, 1'b0},
        '{ROW_BYTE, 8'hFF,              1'b1, 1'b0, 1'b0, 1'b0},
        '{ROW_BYTE, csvx_pkg::CH_QUOTE, 1'b0, 1'b0, 1'b0, 1'b0},
        '{ROW_BYTE, csvx_pkg::CH_NUL,   1'b0, 1'b1, 1'b1, 1'b0},   // NUL in skipped quotes
        '{ROW_BYTE, 8'h7A,              1'b1, 1'b1, 1'b0, 1'b0}
    };

    logic [7:0] phase_tgt [0:N_PHASES-1] = '{8'd3, 8'd1, 8'd2, 8'd0, 8'd12, 8'd255};

    function automatic logic is_blank(input logic [7:0] b);
        return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic logic ends_line(input logic [7:0] b);
        return (b == csvx_pkg::CH_NUL) || (b == csvx_pkg::CH_LF) || (b == csvx_pkg::CH_CR);
    endfunction

    task automatic emit(input logic [7:0] b, input logic cl, input logic fd);
        step_q.push_back({b, cl, fd, 1'b0});
    endtask

    task automatic close_line(input logic fd);
        emit(csvx_pkg::CH_NUL, 1'b1, fd);
        pmode = csvx_pkg::M_DONE;
    endtask

    task automatic restart_line();
        col_num = 8'd1;
        pmode   = csvx_pkg::M_START;
        kept_n  = 0;
        lead_ws = 1'b1;
        ws_n    = 0;
    endtask

    task automatic next_column();
        if (col_num != csvx_pkg::COLUMN_MAX)
            col_num = col_num + 8'd1;
        pmode = csvx_pkg::M_START;
    endtask

    // bytes past capacity are dropped before trimming looks at them
    task automatic keep_byte(input logic [7:0] b);
        if (kept_n < FIELD_CAP - 1) begin
            kept_n++;
            if (is_blank(b)) begin
                if (!lead_ws && ws_n < FIELD_CAP - 1) begin
                    ws_hold[ws_n] = b;
                    ws_n++;
                end
            end else begin
                for (int i = 0; i < ws_n; i++)
                    emit(ws_hold[i], 1'b0, 1'b0);
                ws_n    = 0;
                lead_ws = 1'b0;
                emit(b, 1'b0, 1'b0);
            end
        end
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic fin);
        case (pmode)
            csvx_pkg::M_START: begin
                if (ends_line(b))
                    close_line(1'b0);
                else if (col_num == tgt_col) begin
                    if (b == csvx_pkg::CH_QUOTE)
                        pmode = csvx_pkg::M_TGT_Q;
                    else if (b == csvx_pkg::CH_COMMA)
                        close_line(1'b1);
                    else begin
                        pmode = csvx_pkg::M_TGT_U;
                        keep_byte(b);
                    end
                end else if (b == csvx_pkg::CH_QUOTE)
                    pmode = csvx_pkg::M_SKIP_Q;
                else if (b == csvx_pkg::CH_COMMA)
                    next_column();
                else
                    pmode = csvx_pkg::M_SKIP_U;
            end
            csvx_pkg::M_SKIP_U: begin
                if (ends_line(b))
                    close_line(1'b0);
                else if (b == csvx_pkg::CH_COMMA)
                    next_column();
            end
            csvx_pkg::M_SKIP_Q: begin
                if (b == csvx_pkg::CH_NUL)
                    close_line(1'b0);
                else if (b == csvx_pkg::CH_QUOTE)
                    pmode = csvx_pkg::M_SKIP_QS;
            end
            csvx_pkg::M_SKIP_QS: begin
                if (b == csvx_pkg::CH_QUOTE)
                    pmode = csvx_pkg::M_SKIP_Q;
                else if (b == csvx_pkg::CH_COMMA)
                    next_column();
                else if (ends_line(b))
                    close_line(1'b0);
                else
                    pmode = csvx_pkg::M_SKIP_U;
            end
            csvx_pkg::M_TGT_U: begin
                if (ends_line(b) || b == csvx_pkg::CH_COMMA)
                    close_line(1'b1);
                else
                    keep_byte(b);
            end
            csvx_pkg::M_TGT_Q: begin
                if (b == csvx_pkg::CH_NUL)
                    close_line(1'b1);
                else if (b == csvx_pkg::CH_QUOTE)
                    pmode = csvx_pkg::M_TGT_QS;
                else
                    keep_byte(b);
            end
            csvx_pkg::M_TGT_QS: begin
                if (b == csvx_pkg::CH_QUOTE) begin
                    pmode = csvx_pkg::M_TGT_Q;
                    keep_byte(b);
                end else
                    close_line(1'b1);
            end
            default: ;
        endcase
        if (fin) begin
            if (pmode != csvx_pkg::M_DONE)
                close_line(pmode == csvx_pkg::M_TGT_U || pmode == csvx_pkg::M_TGT_Q ||
                           pmode == csvx_pkg::M_TGT_QS);
            restart_line();
        end
        if (step_q.size() != 0)
            step_q[step_q.size() - 1].last = 1'b1;
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("%0t: mismatch on %s: got %02h, expected %02h", $realtime, what, got, want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_field_out want;
        if (!i_rst_n) begin
            tgt_col = csvx_pkg::TARGET_RESET;
            restart_line();
            field_out_q.delete();
        end else begin
            if (i_cfg_we)
                tgt_col = i_cfg_wdata;
            if (o_m_tvalid && i_m_tready) begin
                if (field_out_q.size() == 0)
                    report_mismatch("unexpected result", o_m_tdata, 8'h00);
                else begin
                    want = field_out_q.pop_front();
                    if (o_m_tdata !== want.fbyte)
                        report_mismatch("field_byte", o_m_tdata, want.fbyte);
                    if (o_m_tuser[0] !== want.closing)
                        report_mismatch("is_closing", {7'd0, o_m_tuser[0]},
                                        {7'd0, want.closing});
                    if (o_m_tuser[1] !== want.found)
                        report_mismatch("column_found", {7'd0, o_m_tuser[1]},
                                        {7'd0, want.found});
                    if (o_m_tlast !== want.last)
                        report_mismatch("burst_last", {7'd0, o_m_tlast}, {7'd0, want.last});
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                step_q.delete();
                parse_byte(i_s_tdata, i_s_tlast);
                if (row_typed) begin
                    step_q.delete();
                    if (row_n)
                        step_q.push_back({csvx_pkg::CH_NUL, 1'b1, row_found, 1'b1});
                end
                foreach (step_q[k])
                    field_out_q.push_back(step_q[k]);
            end
        end
    end

    // watchdog: ends the run when no transfer happens for too long
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= WATCH_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver: random back-pressure, or a long hold-off when asked
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_m_tready = 1'b0;
                hold_left--;
            end else
                i_m_tready = quiet || ($urandom_range(99) >= 30);
        end
    end

    // valid stays high after a transfer; the next call or drain() moves it
    task automatic send_byte(input logic [7:0] b, input logic fin, input logic typed,
                             input logic n_one, input logic fnd);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(99) < 30)
            gap = $urandom_range(1, 2);
        if (gap > 0) begin
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = b;
        i_s_tlast  = fin;
        row_typed  = typed;
        row_n      = n_one;
        row_found  = fnd;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_s_tvalid = 1'b0;
        while (field_out_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_target(input logic [7:0] v);
        i_cfg_wdata = v;
        i_cfg_we    = 1'b1;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    task automatic add_field();
        int   len;
        int   pick;
        logic quoted;
        logic [7:0] ws_pick [0:5];
        ws_pick = '{csvx_pkg::CH_SPACE, csvx_pkg::CH_TAB, 8'h0B, 8'h0C,
                    csvx_pkg::CH_LF, csvx_pkg::CH_CR};
        quoted = ($urandom_range(99) < 35);
        if (quoted)
            line_bytes.push_back(csvx_pkg::CH_QUOTE);
        pick = $urandom_range(99);
        if (pick < 4) begin
            // inner whitespace run up to capacity
            line_bytes.push_back(8'h41);
            repeat (61) line_bytes.push_back(csvx_pkg::CH_SPACE);
            line_bytes.push_back(8'h42);
        end else begin
            len = (pick < 10) ? $urandom_range(55, 75) : $urandom_range(0, 8);
            repeat (len) begin
                pick = $urandom_range(99);
                if (pick < 40)
                    line_bytes.push_back(8'(8'h61 + $urandom_range(25)));
                else if (pick < 65)
                    line_bytes.push_back(ws_pick[$urandom_range(quoted ? 5 : 3)]);
                else if (pick < 75) begin
                    if (quoted) begin
                        line_bytes.push_back(csvx_pkg::CH_QUOTE);
                        line_bytes.push_back(csvx_pkg::CH_QUOTE);
                    end else
                        line_bytes.push_back(8'(8'h80 + $urandom_range(127)));
                end else if (pick < 82 && quoted)
                    line_bytes.push_back(csvx_pkg::CH_COMMA);
                else
                    line_bytes.push_back(8'(8'h30 + $urandom_range(9)));
            end
        end
        if (quoted) begin
            line_bytes.push_back(csvx_pkg::CH_QUOTE);
            if ($urandom_range(99) < 10)
                line_bytes.push_back(8'h71);
        end
    endtask

    task automatic build_line();
        int ncol;
        line_bytes.delete();
        if ($urandom_range(99) < 12) begin
            repeat ($urandom_range(1, 16)) line_bytes.push_back(8'($urandom_range(255)));
        end else begin
            ncol = $urandom_range(1, 6);
            for (int c = 0; c < ncol; c++) begin
                if (c != 0)
                    line_bytes.push_back(csvx_pkg::CH_COMMA);
                add_field();
            end
            case ($urandom_range(3))
                0: ;
                1: line_bytes.push_back(csvx_pkg::CH_LF);
                2: line_bytes.push_back(csvx_pkg::CH_CR);
                default: line_bytes.push_back(csvx_pkg::CH_NUL);
            endcase
            if ($urandom_range(99) < 20)
                repeat ($urandom_range(1, 3)) line_bytes.push_back(8'($urandom_range(255)));
            if (line_bytes.size() == 0)
                line_bytes.push_back(csvx_pkg::CH_LF);
        end
    endtask

    task automatic send_line();
        for (int i = 0; i < line_bytes.size(); i++)
            send_byte(line_bytes[i], i == line_bytes.size() - 1, 1'b0, 1'b0, 1'b0);
    endtask

    initial begin
        int sent;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_CFG) begin
                drain();
                write_target(dir_rows[r].val);
            end else
                send_byte(dir_rows[r].val, dir_rows[r].fin, dir_rows[r].typed,
                          dir_rows[r].n_one, dir_rows[r].fnd);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            drain();
            write_target(phase_tgt[p]);
            quiet = (p == 2);
            // first column is the target here, so the output backs up fast
            if (p == 1)
                hold_left = HOLD_CYCLES;
            sent = 0;
            if (phase_tgt[p] == csvx_pkg::COLUMN_MAX) begin
                line_bytes.delete();
                repeat (254) line_bytes.push_back(csvx_pkg::CH_COMMA);
                line_bytes.push_back(csvx_pkg::CH_SPACE);
                line_bytes.push_back(8'h5A);
                line_bytes.push_back(csvx_pkg::CH_COMMA);
                line_bytes.push_back(8'h51);
                send_line();
                sent = line_bytes.size();
            end
            while (sent < PHASE_ITEMS) begin
                build_line();
                send_line();
                sent += line_bytes.size();
            end
        end
        quiet = 1'b0;
        drain();

        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
